// ===== hw/rtl/vsfa_pkg.sv =====
// Package for the vital-sign fluctuation alarm: register indexes, reset values,
// item kinds and the response type of the mean divider.
// No dependencies.
package vsfa_pkg;

	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned VAL_W = 8;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_HR_FLUCT_MIN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RR_FLUCT_MIN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HR_DEV_PCT   = 2'd2;

	localparam logic [VAL_W-1:0] HR_FLUCT_RST = 8'd15;
	localparam logic [VAL_W-1:0] RR_FLUCT_RST = 8'd4;
	localparam logic [VAL_W-1:0] HR_PCT_RST   = 8'd20;

	localparam logic [14:0] PCT_SCALE = 15'd100;

	// item kinds carried on tuser
	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_CLEAR  = 1'b1;

	typedef struct packed {
		logic             done;
		logic [VAL_W-1:0] quot;
	} div_rsp_t;

endpackage

// ===== hw/rtl/vital_sign_fluctuation_alarm_unit.sv =====
// Vital-sign fluctuation alarm: heart/respiration windows, mean, spread test, edge alarm.
// A clear item, or a sample taken while the windows fill, goes straight to the done state;
// otherwise two passes over the window RAM, two registered reciprocal mean multiplies,
// then threshold and evaluate steps.
// New items are taken only when idle, after the last result has moved to the output register.
// Reset (arst_n low, asynchronous) empties the windows logically and clears the alarm latch.
module vital_sign_fluctuation_alarm_unit #(
	parameter int unsigned WINDOW = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // [7:0] heart_rate, [15:8] resp_rate
	input  logic        s_axis_tuser,  // [0] kind
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // [0] fall_detected, [7:1] zero
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	import vsfa_pkg::*;

	localparam int unsigned PW    = $clog2(WINDOW);
	localparam int unsigned CNT_W = PW + 1;
	localparam int unsigned SUM_W = 8 + $clog2(WINDOW);
	localparam int unsigned SQ_W  = 16 + $clog2(WINDOW);
	localparam int unsigned TH_W  = 17 + $clog2(WINDOW) + 1;

	localparam logic [CNT_W-1:0] CNT_END = CNT_W'(WINDOW);
	localparam logic [PW-1:0]    POS_LAST = PW'(WINDOW - 1);
	localparam logic [TH_W-1:0]  WIN_K = TH_W'(WINDOW);

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_SUM      = 3'd1;
	localparam logic [2:0] S_DIV_GO   = 3'd2;
	localparam logic [2:0] S_DIV_WAIT = 3'd3;
	localparam logic [2:0] S_SQ       = 3'd4;
	localparam logic [2:0] S_THR      = 3'd5;
	localparam logic [2:0] S_EVAL     = 3'd6;
	localparam logic [2:0] S_DONE     = 3'd7;

	logic [2:0]       state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [PW-1:0]    write_pos_q;
	logic             window_full_q;
	logic             alarm_latched_q;
	logic             lane_q;
	logic             res_q;
	logic             m_valid_q;
	logic             fall_q;

	logic [7:0] hr_fluct_q, rr_fluct_q, hr_pct_q;
	logic [7:0] cur_hr_q, hr_mean_q, rr_mean_q;
	logic [SUM_W-1:0] hr_sum_q, rr_sum_q;
	logic [SQ_W-1:0]  hr_sq_q, rr_sq_q;
	logic [15:0]      hr_prod_s2, rr_prod_s2;
	logic             rd_vld_s1, prod_vld_s2;
	logic [16:0]      hr_t2_q, rr_t2_q;
	logic [15:0]      mp_q;
	logic [14:0]      dep100_q;

	logic             accept;
	logic             out_load;
	logic             wrap;
	logic             full_next;
	logic             in_pass;
	logic             rd_issue;
	logic [15:0]      rd_data;
	logic [7:0]       rd_hr, rd_rr, d_hr, d_rr, dep;
	logic [8:0]       hr_t1, rr_t1;
	logic             cond;
	logic             div_start;
	logic [SUM_W-1:0] div_dividend;
	div_rsp_t         div_rsp;

	assign s_axis_tready = (state_q == S_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {7'b0, fall_q};

	// result moves into the output register once the previous beat has left
	assign out_load  = (state_q == S_DONE) && (!m_valid_q || m_axis_tready);

	assign wrap      = (write_pos_q == POS_LAST);
	assign full_next = window_full_q || wrap;
	assign in_pass   = (state_q == S_SUM) || (state_q == S_SQ);
	assign rd_issue  = in_pass && (cnt_q < CNT_END);

	// both windows share one RAM word: resp_rate high, heart_rate low
	vsfa_ram #(
		.WIDTH (16),
		.DEPTH (WINDOW)
	) u_win_ram (
		.clk     (clk),
		.wr_en   (accept && (s_axis_tuser == KIND_SAMPLE)),
		.wr_addr (write_pos_q),
		.wr_data (s_axis_tdata),
		.rd_en   (rd_issue),
		.rd_addr (cnt_q[PW-1:0]),
		.rd_data (rd_data)
	);

	assign rd_hr = rd_data[7:0];
	assign rd_rr = rd_data[15:8];
	assign d_hr  = (rd_hr >= hr_mean_q) ? rd_hr - hr_mean_q : hr_mean_q - rd_hr;
	assign d_rr  = (rd_rr >= rr_mean_q) ? rd_rr - rr_mean_q : rr_mean_q - rd_rr;
	assign dep   = (cur_hr_q >= hr_mean_q) ? cur_hr_q - hr_mean_q : hr_mean_q - cur_hr_q;
	assign hr_t1 = {1'b0, hr_fluct_q} + 9'd1;
	assign rr_t1 = {1'b0, rr_fluct_q} + 9'd1;

	assign div_start    = (state_q == S_DIV_GO);
	assign div_dividend = lane_q ? rr_sum_q : hr_sum_q;

	vsfa_div #(
		.WINDOW (WINDOW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.rsp      (div_rsp)
	);

	// isqrt(sq / W) > T  <=>  sq >= W * (T + 1)^2 ;  dep > mean*pct/100  <=>  100*dep > mean*pct
	assign cond = (TH_W'(hr_sq_q) >= (TH_W)'(WIN_K * TH_W'(hr_t2_q))) &&
	              (TH_W'(rr_sq_q) >= (TH_W)'(WIN_K * TH_W'(rr_t2_q))) &&
	              ({1'b0, dep100_q} > mp_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hr_fluct_q <= HR_FLUCT_RST;
			rr_fluct_q <= RR_FLUCT_RST;
			hr_pct_q   <= HR_PCT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_HR_FLUCT_MIN: hr_fluct_q <= cfg_data;
				REG_RR_FLUCT_MIN: rr_fluct_q <= cfg_data;
				REG_HR_DEV_PCT:   hr_pct_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			cnt_q           <= '0;
			write_pos_q     <= '0;
			window_full_q   <= 1'b0;
			alarm_latched_q <= 1'b0;
			lane_q          <= 1'b0;
			res_q           <= 1'b0;
			m_valid_q       <= 1'b0;
			rd_vld_s1       <= 1'b0;
			prod_vld_s2     <= 1'b0;
		end else begin
			rd_vld_s1   <= rd_issue;
			prod_vld_s2 <= rd_vld_s1 && (state_q == S_SQ);
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_valid_q && m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_q <= 1'b0;
						cnt_q <= '0;
						if (s_axis_tuser == KIND_CLEAR) begin
							alarm_latched_q <= 1'b0;
							state_q         <= S_DONE;
						end else begin
							write_pos_q   <= wrap ? '0 : write_pos_q + 1'b1;
							window_full_q <= full_next;
							state_q       <= full_next ? S_SUM : S_DONE;
						end
					end
				end
				S_SUM: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_END) begin
						lane_q  <= 1'b0;
						state_q <= S_DIV_GO;
					end
				end
				S_DIV_GO: begin
					state_q <= S_DIV_WAIT;
				end
				S_DIV_WAIT: begin
					if (div_rsp.done) begin
						lane_q <= ~lane_q;
						cnt_q  <= '0;
						state_q <= lane_q ? S_SQ : S_DIV_GO;
					end
				end
				S_SQ: begin
					cnt_q <= cnt_q + 1'b1;
					// the pass runs on past the last read until the last product has been summed
					if (cnt_q == CNT_END + 1'b1) begin
						state_q <= S_THR;
					end
				end
				S_THR: begin
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					if (cond) begin
						res_q           <= ~alarm_latched_q;
						alarm_latched_q <= 1'b1;
					end else begin
						res_q           <= 1'b0;
						alarm_latched_q <= 1'b0;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cur_hr_q <= s_axis_tdata[7:0];
			hr_sum_q <= '0;
			rr_sum_q <= '0;
			hr_sq_q  <= '0;
			rr_sq_q  <= '0;
		end
		if (state_q == S_SUM && rd_vld_s1) begin
			hr_sum_q <= hr_sum_q + SUM_W'(rd_hr);
			rr_sum_q <= rr_sum_q + SUM_W'(rd_rr);
		end
		if (state_q == S_DIV_WAIT && div_rsp.done) begin
			if (lane_q) begin
				rr_mean_q <= div_rsp.quot;
			end else begin
				hr_mean_q <= div_rsp.quot;
			end
		end
		if (state_q == S_SQ && rd_vld_s1) begin
			hr_prod_s2 <= 16'(d_hr) * 16'(d_hr);
			rr_prod_s2 <= 16'(d_rr) * 16'(d_rr);
		end
		if (prod_vld_s2) begin
			hr_sq_q <= hr_sq_q + SQ_W'(hr_prod_s2);
			rr_sq_q <= rr_sq_q + SQ_W'(rr_prod_s2);
		end
		if (state_q == S_THR) begin
			hr_t2_q  <= 17'(hr_t1) * 17'(hr_t1);
			rr_t2_q  <= 17'(rr_t1) * 17'(rr_t1);
			mp_q     <= 16'(hr_mean_q) * 16'(hr_pct_q);
			dep100_q <= 15'(dep) * PCT_SCALE;
		end
		if (out_load) begin
			fall_q <= res_q;
		end
	end

	a_full_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		window_full_q |=> window_full_q)
		else $error("window full flag dropped");

	a_pulse_latched: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE) && res_q |-> alarm_latched_q)
		else $error("alarm pulse without latch");

	a_div_owned: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == S_DIV_WAIT))
		else $error("divider finished outside its wait state");

	a_pass_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SUM) |-> (cnt_q <= CNT_END))
		else $error("sum pass ran past the window");

	a_eval_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SUM) |-> window_full_q)
		else $error("window evaluated before it filled");

endmodule

// ===== hw/rtl/vsfa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module vsfa_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== hw/rtl/vsfa_div.sv =====
// Mean of a window sum: multiply by a fixed-point reciprocal of the window length.
// Quotient and done are registered from start and show in the cycle after it. Depends on vsfa_pkg.
module vsfa_div #(
	parameter int unsigned WINDOW = 16,
	localparam int unsigned SUM_W = 8 + $clog2(WINDOW)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [SUM_W-1:0] dividend,
	output vsfa_pkg::div_rsp_t rsp
);

	import vsfa_pkg::*;

	// ceil(2^(SUM_W+L) / WINDOW), L = clog2(WINDOW): exact floor for every SUM_W-bit sum
	localparam int unsigned L_W     = $clog2(WINDOW);
	localparam int unsigned SHIFT   = SUM_W + L_W;
	localparam int unsigned RECIP_W = SUM_W + 1;
	localparam int unsigned PROD_W  = SUM_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((1 << SHIFT) + WINDOW - 1) / WINDOW);

	logic [VAL_W-1:0] quot_q;
	logic             done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= VAL_W'((PROD_W'(dividend) * PROD_W'(RECIP)) >> SHIFT);
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

endmodule

// ===== tb/sv/testbench.sv =====
// Testbench for vital_sign_fluctuation_alarm_unit: directed table, then random episodes
// checked beat by beat against a window/deviation predictor. Depends on vsfa_pkg.
// Runs the block with WINDOW = 16 and randomly stalls both the sender and the receiver.
module testbench;
	import vsfa_pkg::*;

	localparam int WIN = 16;
	localparam int PHASES = 12;
	localparam int PHASE_ITEMS = 112;
	localparam int STALL_LIMIT = 1000;
	localparam int SETTLE_CYCLES = 100;
	// index past the register list, writes to it must be dropped
	localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

	typedef logic [VAL_W-1:0] win_t [WIN];

	typedef struct packed {
		logic             kind;
		logic [VAL_W-1:0] hr;
		logic [VAL_W-1:0] rr;
		logic             known;  // fall is typed in, not predicted
		logic             fall;
	} dir_row_t;

	// fill both windows with extremes, then walk the latch through rise, hold, clear and drop
	localparam dir_row_t DIR_TAB [24] = '{
		'{KIND_CLEAR,  8'd0,   8'd0,   1'b1, 1'b0},
		'{KIND_SAMPLE, 8'd0,   8'd255, 1'b1, 1'b0},
		'{KIND_SAMPLE, 8'd255, 8'd0,   1'b1, 1'b0},
		'{KIND_SAMPLE, 8'd0,   8'd255, 1'b1, 1'b0},
		'{KIND_SAMPLE, 8'd255, 8'd0,   1'b1, 1'b0},
		'{KIND_SAMPLE, 8'd0,   8'd255, 1'b1, 1'b0},
		'{KIND_SAMPLE, 8'd255, 8'd0,   1'b1, 1'b0},
		'{KIND_SAMPLE, 8'd0,   8'd255, 1'b1, 1'b0},
		'{KIND_SAMPLE, 8'd255, 8'd0,   1'b1, 1'b0},
		'{KIND_SAMPLE, 8'd0,   8'd255, 1'b1, 1'b0},
		'{KIND_SAMPLE, 8'd255, 8'd0,   1'b1, 1'b0},
		'{KIND_SAMPLE, 8'd0,   8'd255, 1'b1, 1'b0},
		'{KIND_SAMPLE, 8'd255, 8'd0,   1'b1, 1'b0},
		'{KIND_SAMPLE, 8'd0,   8'd255, 1'b1, 1'b0},
		'{KIND_SAMPLE, 8'd255, 8'd0,   1'b1, 1'b0},
		'{KIND_SAMPLE, 8'd0,   8'd255, 1'b1, 1'b0},
		'{KIND_SAMPLE, 8'd255, 8'd0,   1'b0, 1'b0},
		'{KIND_SAMPLE, 8'd0,   8'd255, 1'b0, 1'b0},
		'{KIND_CLEAR,  8'd255, 8'd255, 1'b1, 1'b0},
		'{KIND_SAMPLE, 8'd255, 8'd0,   1'b0, 1'b0},
		'{KIND_SAMPLE, 8'd128, 8'd255, 1'b0, 1'b0},
		'{KIND_SAMPLE, 8'd255, 8'd0,   1'b0, 1'b0},
		'{KIND_SAMPLE, 8'd1,   8'd254, 1'b0, 1'b0},
		'{KIND_CLEAR,  8'd0,   8'd0,   1'b1, 1'b0}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;  // [7:0] heart_rate, [15:8] resp_rate
	logic        s_axis_tuser = 1'b0;  // [0] kind
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;  // [0] fall_detected, [7:1] zero
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [7:0]  cfg_data = '0;

	// predictor state
	win_t             hr_win;
	win_t             rr_win;
	int unsigned      wr_pos = 0;
	bit               win_full = 1'b0;
	bit               alarm_on = 1'b0;
	logic [VAL_W-1:0] hr_fluct_thr = HR_FLUCT_RST;
	logic [VAL_W-1:0] rr_fluct_thr = RR_FLUCT_RST;
	logic [VAL_W-1:0] hr_pct = HR_PCT_RST;

	logic fall_q [$];
	logic fall_exp;
	int   err_cnt = 0;
	int   quiet_cycles = 0;
	int   stall_left = 0;
	bit   calm_flow = 1'b0;

	// random episode generator
	int style;
	int base_hr;
	int base_rr;
	int spread_hr;
	int spread_rr;
	int burst_left;

	vital_sign_fluctuation_alarm_unit #(
		.WINDOW(WIN)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic void window_stats(input win_t w, output int unsigned mean,
			output int unsigned dev);
		int unsigned sum;
		int unsigned msq;
		int unsigned d;
		int unsigned r;
		sum = 0;
		msq = 0;
		r = 0;
		for (int i = 0; i < WIN; i++)
			sum += w[i];
		mean = sum / WIN;
		for (int i = 0; i < WIN; i++) begin
			d = (w[i] >= mean) ? w[i] - mean : mean - w[i];
			msq += d * d;
		end
		msq = msq / WIN;
		while ((r + 1) * (r + 1) <= msq)
			r++;
		dev = r;
	endfunction

	// updates the predictor state and returns the expected fall_detected
	function automatic logic fall_model(input logic kind, input logic [VAL_W-1:0] hr,
			input logic [VAL_W-1:0] rr);
		int unsigned hr_mean;
		int unsigned hr_dev;
		int unsigned rr_mean;
		int unsigned rr_dev;
		int unsigned dep;
		logic        hit;
		if (kind == KIND_CLEAR) begin
			alarm_on = 1'b0;
			return 1'b0;
		end
		hr_win[wr_pos] = hr;
		rr_win[wr_pos] = rr;
		wr_pos = (wr_pos + 1) % WIN;
		if (wr_pos == 0)
			win_full = 1'b1;
		if (!win_full)
			return 1'b0;
		window_stats(hr_win, hr_mean, hr_dev);
		window_stats(rr_win, rr_mean, rr_dev);
		dep = (hr >= hr_mean) ? hr - hr_mean : hr_mean - hr;
		hit = hr_dev > hr_fluct_thr && rr_dev > rr_fluct_thr &&
			dep > (hr_mean * hr_pct) / PCT_SCALE;
		if (!hit) begin
			alarm_on = 1'b0;
			return 1'b0;
		end
		if (alarm_on)
			return 1'b0;
		alarm_on = 1'b1;
		return 1'b1;
	endfunction

	function automatic logic [VAL_W-1:0] pick_thr(input int hi);
		unique case ($urandom_range(0, 3))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom_range(0, hi));
		endcase
	endfunction

	function automatic int clamp_val(input int v);
		return (v < 0) ? 0 : (v > 255) ? 255 : v;
	endfunction

	// calm baseline with random fluctuation bursts, a spread baseline, or plain noise
	function automatic void gen_item(output logic kind, output logic [VAL_W-1:0] hr,
			output logic [VAL_W-1:0] rr);
		int h;
		int r;
		kind = ($urandom_range(0, 9) == 0) ? KIND_CLEAR : KIND_SAMPLE;
		unique case (style)
			0: begin
				h = $urandom_range(0, 255);
				r = $urandom_range(0, 255);
			end
			1: begin
				h = base_hr + int'($urandom_range(0, 2 * spread_hr)) - spread_hr;
				r = base_rr + int'($urandom_range(0, 2 * spread_rr)) - spread_rr;
			end
			default: begin
				if (burst_left > 0) begin
					burst_left--;
					h = $urandom_range(0, 255);
					r = $urandom_range(0, 255);
				end else begin
					if ($urandom_range(0, 11) == 0)
						burst_left = $urandom_range(1, 6);
					h = base_hr + int'($urandom_range(0, 6)) - 3;
					r = base_rr + int'($urandom_range(0, 4)) - 2;
				end
			end
		endcase
		hr = 8'(clamp_val(h));
		rr = 8'(clamp_val(r));
	endfunction

	task automatic flag_mismatch(input string what, input int got, input int want);
		err_cnt++;
		$display("MISMATCH %s: got %0d, expected %0d", what, got, want);
	endtask

	// holds the beat until accepted; tvalid stays high for a following beat
	task automatic send_item(input logic kind, input logic [VAL_W-1:0] hr,
			input logic [VAL_W-1:0] rr, input logic known, input logic fall);
		logic pred;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {rr, hr};
		s_axis_tuser <= kind;
		do @(posedge clk); while (!s_axis_tready);
		pred = fall_model(kind, hr, rr);
		fall_q.push_back(known ? fall : pred);
	endtask

	task automatic sender_gap(input int n);
		s_axis_tvalid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (fall_q.size() != 0);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		unique case (idx)
			REG_HR_FLUCT_MIN: hr_fluct_thr = val;
			REG_RR_FLUCT_MIN: rr_fluct_thr = val;
			REG_HR_DEV_PCT: hr_pct = val;
			default: ;
		endcase
	endtask

	task automatic set_config(input logic [VAL_W-1:0] hf, input logic [VAL_W-1:0] rf,
			input logic [VAL_W-1:0] pct);
		write_reg(REG_HR_FLUCT_MIN, hf);
		write_reg(REG_RR_FLUCT_MIN, rf);
		if ($urandom_range(0, 2) == 0)
			write_reg(REG_NONE, 8'($urandom_range(0, 255)));
		write_reg(REG_HR_DEV_PCT, pct);
		cfg_valid <= 1'b0;
	endtask

	// receiver: ready drops in randomly drawn stall bursts; calm_flow holds it high
	always @(posedge clk) begin
		if (calm_flow) begin
			m_axis_tready <= 1'b1;
		end else if (stall_left > 0) begin
			m_axis_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 5) == 0) begin
			m_axis_tready <= 1'b0;
			stall_left <= $urandom_range(0, 7);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) begin
			if (fall_q.size() == 0) begin
				flag_mismatch("unexpected beat, fall_detected", m_axis_tdata[0], 0);
			end else begin
				fall_exp = fall_q.pop_front();
				if (m_axis_tdata[0] !== fall_exp)
					flag_mismatch("fall_detected", m_axis_tdata[0], fall_exp);
				if (m_axis_tdata[7:1] !== 7'd0)
					flag_mismatch("tdata padding", m_axis_tdata[7:1], 0);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == STALL_LIMIT) begin
			$display("vital_sign_fluctuation_alarm_unit test failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		logic             kind;
		logic [VAL_W-1:0] hr;
		logic [VAL_W-1:0] rr;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// out-of-range index first: the directed rows rely on the reset thresholds
		write_reg(REG_NONE, 8'hFF);
		cfg_valid <= 1'b0;
		foreach (DIR_TAB[i])
			send_item(DIR_TAB[i].kind, DIR_TAB[i].hr, DIR_TAB[i].rr, DIR_TAB[i].known,
				DIR_TAB[i].fall);

		for (int p = 0; p < PHASES; p++) begin
			drain();
			repeat (4) @(posedge clk);
			unique case (p)
				0: set_config(HR_FLUCT_RST, RR_FLUCT_RST, HR_PCT_RST);
				1: set_config(8'd0, 8'd0, 8'd0);
				2: set_config(8'd255, 8'd255, 8'd255);
				3: set_config(8'd0, 8'd0, 8'd255);
				4: set_config(8'd255, 8'd0, 8'd0);
				default: set_config(pick_thr(40), pick_thr(12), pick_thr(100));
			endcase
			style = (p == 1) ? 0 : $urandom_range(0, 3);
			base_hr = $urandom_range(40, 180);
			base_rr = $urandom_range(6, 40);
			spread_hr = $urandom_range(0, 60);
			spread_rr = $urandom_range(0, 20);
			burst_left = 0;
			calm_flow = (p == PHASES - 1) || ($urandom_range(0, 3) == 0);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				gen_item(kind, hr, rr);
				send_item(kind, hr, rr, 1'b0, 1'b0);
				if (!calm_flow) begin
					if ($urandom_range(0, 5) == 0)
						sender_gap($urandom_range(1, 8));
					else if ($urandom_range(0, 59) == 0)
						drain();
				end
			end
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (err_cnt == 0)
			$display("vital_sign_fluctuation_alarm_unit test passed");
		else
			$display("vital_sign_fluctuation_alarm_unit test failed");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/vsfa_pkg.sv
hw/rtl/vsfa_ram.sv
hw/rtl/vsfa_div.sv
hw/rtl/vital_sign_fluctuation_alarm_unit.sv
tb/sv/testbench.sv
